// File: rtl/lru_wsr_page_buffer_policy_assert.svh
// Assertion macros used by the page-buffer policy top module.
`ifndef LRU_WSR_PAGE_BUFFER_POLICY_ASSERT_SVH
`define LRU_WSR_PAGE_BUFFER_POLICY_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LWPB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LWPB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lwpb_pkg.sv
// Types and constants shared by the page-buffer policy modules.
package lwpb_pkg;

    // Action codes.
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COLD      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b1;

    // Most write-back beats one flush may produce.
    localparam logic [7:0] MAX_RESULTS = 8'd16;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] page_id;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [3:0]  slot;
        logic        fetch_from_device;
        logic        writeback;
        logic [31:0] writeback_page;
        logic        last;
    } out_item_t;

    // Controller to output stage.
    typedef struct packed {
        logic      load;
        out_item_t item;
    } emit_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SW_SEARCH,
        SW_UPDATE,
        SW_FLUSH
    } sweep_t;

endpackage

// File: rtl/lru_wsr_page_buffer_policy.sv
// Sequence: an access takes one search sweep and one update sweep, plus one more sweep
// per second chance given to a dirty frame. A flush takes one search sweep and one
// sweep per recency rank visited.
// Throughput: one item at a time; the single read port of the frame memory sets the pace.
// Reset clears the valid bits, occupancy and control; max_cold resets to 1 and
// frames_in_use to 16.
module lru_wsr_page_buffer_policy
    import lwpb_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

`include "lru_wsr_page_buffer_policy_assert.svh"

    logic [7:0] max_cold_reg, max_cold_next;
    logic [4:0] fiu_reg, fiu_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic       out_free;
    emit_t      emit;

    lwpb_ctrl #(
        .FRAMES (FRAMES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_data       (in_data),
        .in_ready      (in_ready),
        .max_cold      (max_cold_reg),
        .frames_in_use (fiu_reg),
        .out_free      (out_free),
        .emit          (emit)
    );

    // Configuration writes.
    always_comb
    begin
        max_cold_next = max_cold_reg;
        fiu_next      = fiu_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_COLD:      max_cold_next = cfg_data;
                REG_FRAMES_IN_USE: fiu_next      = cfg_data[4:0];
                default:           max_cold_next = max_cold_reg;
            endcase
        end
    end

    // Output register: a beat may wait here while the controller moves on.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit.load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit.item;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cold_reg  <= 8'd1;
            fiu_reg       <= 5'd16;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_cold_reg  <= max_cold_next;
            fiu_reg       <= fiu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The controller is busy in the cycle after it takes a beat.
    `LWPB_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    // A result is only loaded into a free output register.
    `LWPB_ASSERT_IMP(a_load_free, emit.load, !out_valid_reg || out_ready, "output overrun")
    // No result is produced while idle.
    `LWPB_ASSERT_IMP(a_no_idle_emit, emit.load, !in_ready, "result while idle")

endmodule

// File: rtl/lwpb_frame_ram.sv
// Frame record memory: one write port, one registered read port.
module lwpb_frame_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 48
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lwpb_ctrl.sv
// Sweep controller: searches, reorders and flushes the frame records in memory.
module lwpb_ctrl
    import lwpb_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_item_t in_data,
    output logic     in_ready,
    input  logic [7:0] max_cold,
    input  logic [4:0] frames_in_use,
    input  logic     out_free,
    output emit_t    emit
);

    localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int OW = RW + 1;
    localparam int DW = 32 + 1 + 8 + RW;

    // Control registers.
    state_t            state_reg, state_next;
    sweep_t            kind_reg, kind_next;
    logic [FRAMES-1:0] valid_reg, valid_next;
    logic [OW-1:0]     occ_reg, occ_next;
    logic [OW-1:0]     cnt_reg, cnt_next;
    logic              pv_reg, pv_next;
    logic              hit_found_reg, hit_found_next;
    logic              found_reg, found_next;
    logic              rotate_reg, rotate_next;
    logic [7:0]        dcnt_reg, dcnt_next;
    logic [7:0]        emitted_reg, emitted_next;

    // Payload registers.
    logic [RW-1:0]     pidx_reg, pidx_next;
    logic [1:0]        action_reg, action_next;
    logic [31:0]       page_reg, page_next;
    logic [RW-1:0]     hit_idx_reg, hit_idx_next;
    logic [RW-1:0]     hit_rank_reg, hit_rank_next;
    logic              hit_dirty_reg, hit_dirty_next;
    logic [RW-1:0]     lru_idx_reg, lru_idx_next;
    logic [31:0]       lru_tag_reg, lru_tag_next;
    logic              lru_dirty_reg, lru_dirty_next;
    logic [7:0]        lru_cold_reg, lru_cold_next;
    logic [RW-1:0]     tgt_idx_reg, tgt_idx_next;
    logic [OW-1:0]     thr_reg, thr_next;
    logic [31:0]       tgt_tag_reg, tgt_tag_next;
    logic              tgt_dirty_reg, tgt_dirty_next;
    logic [7:0]        tgt_cold_reg, tgt_cold_next;
    logic [OW-1:0]     fl_rank_reg, fl_rank_next;
    logic [RW-1:0]     fl_slot_reg, fl_slot_next;
    logic [31:0]       fl_tag_reg, fl_tag_next;
    logic [7:0]        ntgt_reg, ntgt_next;
    out_item_t         res_reg, res_next;

    // Memory port signals.
    logic              mem_we;
    logic [RW-1:0]     mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic [RW-1:0]     mem_raddr;
    logic [DW-1:0]     mem_rdata;

    // Decoded read word and helpers.
    logic [31:0]       rd_tag;
    logic              rd_dirty;
    logic [7:0]        rd_cold;
    logic [RW-1:0]     rd_rank;
    logic              rd_v;
    logic              issue;
    logic              sweep_done;
    logic [7:0]        cap8;
    logic [OW-1:0]     cap;
    logic [OW-1:0]     occ_m1;
    logic              is_acc;
    logic              is_flush;
    logic              rotate_cond;
    logic [RW-1:0]     free_idx;
    logic [RW-1:0]     new_rank;

    lwpb_frame_ram #(
        .DEPTH (FRAMES),
        .AW    (RW),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_tag   = mem_rdata[DW-1 -: 32];
    assign rd_dirty = mem_rdata[RW+8];
    assign rd_cold  = mem_rdata[RW+7:RW];
    assign rd_rank  = mem_rdata[RW-1:0];
    assign rd_v     = valid_reg[pidx_reg];

    // Sweep address sequencing: one read issued per cycle.
    assign issue      = (state_reg == ST_SWEEP) && (cnt_reg < OW'(FRAMES));
    assign mem_raddr  = cnt_reg[RW-1:0];
    assign sweep_done = (state_reg == ST_SWEEP) && !issue && !pv_reg;

    // Effective frame limit: zero acts as one, large values clamp to the depth.
    assign cap8 = (frames_in_use == 5'd0) ? 8'd1 :
                  (({3'b000, frames_in_use} > 8'(FRAMES)) ? 8'(FRAMES)
                                                          : {3'b000, frames_in_use});
    assign cap    = OW'(cap8);
    assign occ_m1 = occ_reg - OW'(1);

    assign is_acc      = (action_reg == ACT_READ) || (action_reg == ACT_WRITE);
    assign is_flush    = (action_reg == ACT_FLUSH);
    assign rotate_cond = lru_dirty_reg && (lru_cold_reg < max_cold);

    // Lowest frame that holds no page.
    always_comb
    begin
        free_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = RW'(i);
            end
        end
    end

    // Rank after the move-to-head of the target frame.
    assign new_rank = (OW'(rd_rank) < thr_reg) ? (rd_rank + RW'(1)) : rd_rank;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                case (kind_reg)
                    SW_SEARCH:
                    begin
                        if (is_flush)
                        begin
                            state_next = (dcnt_reg == 8'd0) ? ST_IDLE : ST_SWEEP;
                        end
                        else if (!is_acc)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_SWEEP;
                        end
                    end
                    SW_UPDATE:
                    begin
                        state_next = rotate_reg ? ST_SWEEP : ST_EMIT;
                    end
                    SW_FLUSH:
                    begin
                        state_next = found_reg ? ST_EMIT : ST_SWEEP;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ((kind_reg == SW_FLUSH) && !res_reg.last) ? ST_SWEEP
                                                                           : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        emit.load = (state_reg == ST_EMIT) && out_free;
        emit.item = res_reg;
    end

    // Datapath: sweep processing, decisions and bookkeeping.
    always_comb
    begin
        kind_next      = kind_reg;
        valid_next     = valid_reg;
        occ_next       = occ_reg;
        cnt_next       = cnt_reg;
        pv_next        = issue;
        pidx_next      = cnt_reg[RW-1:0];
        hit_found_next = hit_found_reg;
        found_next     = found_reg;
        rotate_next    = rotate_reg;
        dcnt_next      = dcnt_reg;
        emitted_next   = emitted_reg;
        action_next    = action_reg;
        page_next      = page_reg;
        hit_idx_next   = hit_idx_reg;
        hit_rank_next  = hit_rank_reg;
        hit_dirty_next = hit_dirty_reg;
        lru_idx_next   = lru_idx_reg;
        lru_tag_next   = lru_tag_reg;
        lru_dirty_next = lru_dirty_reg;
        lru_cold_next  = lru_cold_reg;
        tgt_idx_next   = tgt_idx_reg;
        thr_next       = thr_reg;
        tgt_tag_next   = tgt_tag_reg;
        tgt_dirty_next = tgt_dirty_reg;
        tgt_cold_next  = tgt_cold_reg;
        fl_rank_next   = fl_rank_reg;
        fl_slot_next   = fl_slot_reg;
        fl_tag_next    = fl_tag_reg;
        ntgt_next      = ntgt_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = pidx_reg;
        mem_wdata      = mem_rdata;

        if (issue)
        begin
            cnt_next = cnt_reg + OW'(1);
        end

        // Accept a new beat and start the search sweep.
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            action_next    = in_data.action;
            page_next      = in_data.page_id;
            kind_next      = SW_SEARCH;
            cnt_next       = '0;
            hit_found_next = 1'b0;
            dcnt_next      = 8'd0;
        end

        // Process the word read back during a sweep.
        if (pv_reg)
        begin
            case (kind_reg)
                SW_SEARCH:
                begin
                    if (rd_v && (rd_tag == page_reg) && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = pidx_reg;
                        hit_rank_next  = rd_rank;
                        hit_dirty_next = rd_dirty;
                    end
                    if (rd_v && (OW'(rd_rank) == occ_m1))
                    begin
                        lru_idx_next   = pidx_reg;
                        lru_tag_next   = rd_tag;
                        lru_dirty_next = rd_dirty;
                        lru_cold_next  = rd_cold;
                    end
                    if (rd_v && rd_dirty)
                    begin
                        dcnt_next = dcnt_reg + 8'd1;
                    end
                end
                SW_UPDATE:
                begin
                    if (pidx_reg == tgt_idx_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {tgt_tag_reg, tgt_dirty_reg, tgt_cold_reg, RW'(0)};
                        if (occ_m1 == '0)
                        begin
                            lru_idx_next   = pidx_reg;
                            lru_tag_next   = tgt_tag_reg;
                            lru_dirty_next = tgt_dirty_reg;
                            lru_cold_next  = tgt_cold_reg;
                        end
                    end
                    else if (rd_v)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = {rd_tag, rd_dirty, rd_cold, new_rank};
                        if (OW'(new_rank) == occ_m1)
                        begin
                            lru_idx_next   = pidx_reg;
                            lru_tag_next   = rd_tag;
                            lru_dirty_next = rd_dirty;
                            lru_cold_next  = rd_cold;
                        end
                    end
                end
                SW_FLUSH:
                begin
                    if (rd_v && rd_dirty && (OW'(rd_rank) == fl_rank_reg))
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = {rd_tag, 1'b0, rd_cold, rd_rank};
                        found_next   = 1'b1;
                        fl_slot_next = pidx_reg;
                        fl_tag_next  = rd_tag;
                    end
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end

        // Choose the next sweep once the current one has finished.
        if (state_reg == ST_DECIDE)
        begin
            cnt_next = '0;
            if (kind_reg == SW_FLUSH)
            begin
                if (found_reg)
                begin
                    res_next.hit               = 1'b0;
                    res_next.slot              = 4'(fl_slot_reg);
                    res_next.fetch_from_device = 1'b0;
                    res_next.writeback         = 1'b1;
                    res_next.writeback_page    = fl_tag_reg;
                    res_next.last              = ((emitted_reg + 8'd1) == ntgt_reg);
                end
                else
                begin
                    fl_rank_next = fl_rank_reg + OW'(1);
                end
            end
            else if (is_flush)
            begin
                kind_next    = SW_FLUSH;
                fl_rank_next = '0;
                emitted_next = 8'd0;
                found_next   = 1'b0;
                ntgt_next    = (dcnt_reg > MAX_RESULTS) ? MAX_RESULTS : dcnt_reg;
            end
            else if (!is_acc || ((kind_reg == SW_UPDATE) && !rotate_reg))
            begin
                // Unused action, or the final update sweep is done: nothing to choose.
                kind_next = kind_reg;
            end
            else if ((kind_reg == SW_SEARCH) && hit_found_reg)
            begin
                // Hit: move to head, clear the cold count.
                kind_next      = SW_UPDATE;
                rotate_next    = 1'b0;
                tgt_idx_next   = hit_idx_reg;
                thr_next       = OW'(hit_rank_reg);
                tgt_tag_next   = page_reg;
                tgt_dirty_next = hit_dirty_reg || (action_reg == ACT_WRITE);
                tgt_cold_next  = 8'd0;
                res_next.hit               = 1'b1;
                res_next.slot              = 4'(hit_idx_reg);
                res_next.fetch_from_device = 1'b0;
                res_next.writeback         = 1'b0;
                res_next.writeback_page    = 32'd0;
                res_next.last              = 1'b1;
            end
            else if ((kind_reg == SW_SEARCH) && (occ_reg < cap))
            begin
                // Miss with room: take the lowest free frame.
                kind_next      = SW_UPDATE;
                rotate_next    = 1'b0;
                tgt_idx_next   = free_idx;
                thr_next       = OW'(FRAMES);
                tgt_tag_next   = page_reg;
                tgt_dirty_next = (action_reg == ACT_WRITE);
                tgt_cold_next  = 8'd0;
                valid_next[free_idx] = 1'b1;
                occ_next       = occ_reg + OW'(1);
                res_next.hit               = 1'b0;
                res_next.slot              = 4'(free_idx);
                res_next.fetch_from_device = (action_reg == ACT_READ);
                res_next.writeback         = 1'b0;
                res_next.writeback_page    = 32'd0;
                res_next.last              = 1'b1;
            end
            else if (rotate_cond)
            begin
                // Second chance: bump the cold count and move to head.
                kind_next      = SW_UPDATE;
                rotate_next    = 1'b1;
                tgt_idx_next   = lru_idx_reg;
                thr_next       = occ_m1;
                tgt_tag_next   = lru_tag_reg;
                tgt_dirty_next = lru_dirty_reg;
                tgt_cold_next  = lru_cold_reg + 8'd1;
            end
            else
            begin
                // Evict the least recent frame.
                kind_next      = SW_UPDATE;
                rotate_next    = 1'b0;
                tgt_idx_next   = lru_idx_reg;
                thr_next       = occ_m1;
                tgt_tag_next   = page_reg;
                tgt_dirty_next = (action_reg == ACT_WRITE);
                tgt_cold_next  = 8'd0;
                res_next.hit               = 1'b0;
                res_next.slot              = 4'(lru_idx_reg);
                res_next.fetch_from_device = (action_reg == ACT_READ);
                res_next.writeback         = lru_dirty_reg;
                res_next.writeback_page    = lru_dirty_reg ? lru_tag_reg : 32'd0;
                res_next.last              = 1'b1;
            end
        end

        // A flush beat leaves: look for the next rank.
        if ((state_reg == ST_EMIT) && out_free && (kind_reg == SW_FLUSH))
        begin
            emitted_next = emitted_reg + 8'd1;
            fl_rank_next = fl_rank_reg + OW'(1);
            found_next   = 1'b0;
            cnt_next     = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= SW_SEARCH;
            valid_reg     <= '0;
            occ_reg       <= '0;
            cnt_reg       <= '0;
            pv_reg        <= 1'b0;
            hit_found_reg <= 1'b0;
            found_reg     <= 1'b0;
            rotate_reg    <= 1'b0;
            dcnt_reg      <= 8'd0;
            emitted_reg   <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            valid_reg     <= valid_next;
            occ_reg       <= occ_next;
            cnt_reg       <= cnt_next;
            pv_reg        <= pv_next;
            hit_found_reg <= hit_found_next;
            found_reg     <= found_next;
            rotate_reg    <= rotate_next;
            dcnt_reg      <= dcnt_next;
            emitted_reg   <= emitted_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pidx_reg      <= pidx_next;
        action_reg    <= action_next;
        page_reg      <= page_next;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        hit_dirty_reg <= hit_dirty_next;
        lru_idx_reg   <= lru_idx_next;
        lru_tag_reg   <= lru_tag_next;
        lru_dirty_reg <= lru_dirty_next;
        lru_cold_reg  <= lru_cold_next;
        tgt_idx_reg   <= tgt_idx_next;
        thr_reg       <= thr_next;
        tgt_tag_reg   <= tgt_tag_next;
        tgt_dirty_reg <= tgt_dirty_next;
        tgt_cold_reg  <= tgt_cold_next;
        fl_rank_reg   <= fl_rank_next;
        fl_slot_reg   <= fl_slot_next;
        fl_tag_reg    <= fl_tag_next;
        ntgt_reg      <= ntgt_next;
        res_reg       <= res_next;
    end

endmodule
